/* rtl/core/lrupr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// Used by lrupr_cell, lru_page_replacement, lrupr_assert, lrupr_checker and tb; depends on nothing.
package lrupr_pkg;

   // Parameter defaults and the largest supported values.
   localparam int FRAME_COUNT_DEF = 16;
   localparam int PAGE_BITS_DEF   = 16;
   localparam int FRAME_COUNT_MAX = 64;
   localparam int PAGE_W_MAX      = 32;
   localparam int IDX_W_MAX       = $clog2(FRAME_COUNT_MAX);
   localparam int ACT_W_MAX       = IDX_W_MAX + 1;

   // Field widths on the ports.
   localparam int PAGE_W      = 16;
   localparam int FRAME_IDX_W = 4;
   localparam int COUNT_W     = 32;
   localparam int CFG_W       = 5;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   // Response tdata layout, lowest bit first.
   localparam int RSP_HIT_BIT  = 0;
   localparam int RSP_IDX_LO   = RSP_HIT_BIT + 1;
   localparam int RSP_EVV_BIT  = RSP_IDX_LO + FRAME_IDX_W;
   localparam int RSP_EVP_LO   = RSP_EVV_BIT + 1;
   localparam int RSP_HTOT_LO  = RSP_EVP_LO + PAGE_W;
   localparam int RSP_FTOT_LO  = RSP_HTOT_LO + COUNT_W;
   localparam int RSP_FIELDS_W = RSP_FTOT_LO + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Search token that walks down the chain of frame cells.
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [IDX_W_MAX-1:0]  hit_idx;
      logic [IDX_W_MAX-1:0]  hit_rank;
      logic                  empty;
      logic [IDX_W_MAX-1:0]  empty_idx;
      logic [IDX_W_MAX-1:0]  lru_idx;
      logic [IDX_W_MAX-1:0]  lru_rank;
      logic [PAGE_W_MAX-1:0] lru_page;
   } lrupr_tok_type;

   // Update broadcast to every cell when a request commits.
   typedef struct packed {
      logic                  valid;
      logic                  write;
      logic                  age_all;
      logic [IDX_W_MAX-1:0]  idx;
      logic [IDX_W_MAX-1:0]  limit;
      logic [PAGE_W_MAX-1:0] page;
   } lrupr_upd_type;

endpackage

/* rtl/core/lrupr_cell.sv */
// One page frame of the LRU chain: page, valid bit, recency rank and a token stage.
// Depends on lrupr_pkg.
module lrupr_cell
   import lrupr_pkg::*;
#(
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int PAGE_BITS   = PAGE_BITS_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 hold,
   input  logic [PAGE_BITS-1:0] page,
   input  logic [ACT_W_MAX-1:0] act,
   input  lrupr_tok_type        tok_i,
   output lrupr_tok_type        tok_o,
   input  lrupr_upd_type        upd
);

   localparam int IDX_W = $clog2(FRAME_COUNT);
   localparam logic [IDX_W_MAX-1:0] MY_IDX = IDX_W_MAX'(CELL_INDEX);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 valid_ff, valid_in;
   logic [IDX_W-1:0]     rank_ff, rank_in;
   lrupr_tok_type        tok_ff, tok_in;

   logic                 active;
   logic [IDX_W_MAX-1:0] rank_ext;

   assign active   = ACT_W_MAX'(CELL_INDEX) < act;
   assign rank_ext = IDX_W_MAX'(rank_ff);

   // Fold this frame into the search token.
   always_comb begin
      tok_in = tok_i;
      if (!tok_i.hit && active && valid_ff && page_ff == page) begin
         tok_in.hit      = 1'b1;
         tok_in.hit_idx  = MY_IDX;
         tok_in.hit_rank = rank_ext;
      end
      if (!tok_i.empty && active && !valid_ff) begin
         tok_in.empty     = 1'b1;
         tok_in.empty_idx = MY_IDX;
      end
      if (active && (CELL_INDEX == 0 || rank_ext > tok_i.lru_rank)) begin
         tok_in.lru_idx  = MY_IDX;
         tok_in.lru_rank = rank_ext;
         tok_in.lru_page = PAGE_W_MAX'(page_ff);
      end
      if (hold) begin
         tok_in = tok_ff;
      end
   end

   // Apply the committed replacement decision.
   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.valid) begin
         if (upd.idx == MY_IDX) begin
            rank_in = '0;
            if (upd.write) begin
               page_in  = upd.page[PAGE_BITS-1:0];
               valid_in = 1'b1;
            end
         end else if (valid_ff && (upd.age_all || rank_ext < upd.limit)) begin
            rank_in = rank_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign tok_o = tok_ff;

endmodule

/* rtl/core/lru_page_replacement.sv */
// Top level of the LRU page replacement block: stream ports, the frame cell chain,
// the commit decision, counters and the response register. Depends on lrupr_pkg, lrupr_cell.
//
// Each request carries one page number. The block takes one request at a time:
// after acceptance a search token walks down a chain of FRAME_COUNT frame cells,
// one cell per cycle, collecting the first hit, the first empty frame and the
// least recently used frame among the active frames. When the token leaves the
// last cell the decision is broadcast to all cells at once and the response
// is loaded into the output register, which drives rsp_tvalid. A new request is
// accepted in the cycle after the previous one commits, even while its response
// still waits on rsp_tready; a stalled response holds the finished token in place.
// The csr port sets how many frames take part in replacement (0 acts as 1, values
// above FRAME_COUNT act as FRAME_COUNT) and is meant to be written while idle.
// Frames outside the active set keep their pages, are not searched, but still age.
// Hit and fault totals saturate at their maximum. No clearing pass is needed:
// valid bits are cleared by reset.
module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel. tdata: page_number[15:0].
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PAGE_W-1:0]      req_tdata,
   // Response channel. tdata: hit[0], frame_index[4:1], evicted_valid[5],
   // evicted_page[21:6], hit_total[53:22], fault_total[85:54], zero fill above.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration write: frames_in_use.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_data
);

   logic [CFG_W-1:0]     cfg_ff, cfg_in;
   logic                 busy_ff, busy_in;
   logic                 start_ff, start_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]   fault_cnt_ff, fault_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 commit;
   logic                 hold;
   logic [ACT_W_MAX-1:0] act;
   logic [ACT_W_MAX-1:0] cfg_ext;
   logic [PAGE_W_MAX-1:0] req_page_ext;
   lrupr_tok_type        tok_first;
   lrupr_tok_type        tok_chain [FRAME_COUNT+1];
   lrupr_tok_type        tok_last;
   lrupr_upd_type        upd;
   logic [IDX_W_MAX-1:0] frame_sel;
   logic                 evicted;
   logic [PAGE_W_MAX-1:0] ev_page;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;

   // Clamp the configured frame count to 1 .. FRAME_COUNT.
   assign cfg_ext = ACT_W_MAX'(cfg_ff);
   always_comb begin
      act = cfg_ext;
      if (cfg_ff == '0) begin
         act = ACT_W_MAX'(1);
      end else if (cfg_ext > ACT_W_MAX'(FRAME_COUNT)) begin
         act = ACT_W_MAX'(FRAME_COUNT);
      end
   end

   // The chain starts with an empty token that is valid for one cycle.
   always_comb begin
      tok_first       = '0;
      tok_first.valid = start_ff;
   end

   assign tok_chain[0] = tok_first;

   genvar gi;
   generate
      for (gi = 0; gi < FRAME_COUNT; gi++) begin : g_cell
         lrupr_cell #(
            .FRAME_COUNT (FRAME_COUNT),
            .PAGE_BITS   (PAGE_BITS),
            .CELL_INDEX  (gi)
         ) u_cell (
            .clock (clock),
            .reset (reset),
            .hold  (hold),
            .page  (page_ff),
            .act   (act),
            .tok_i (tok_chain[gi]),
            .tok_o (tok_chain[gi+1]),
            .upd   (upd)
         );
      end
   endgenerate

   assign tok_last = tok_chain[FRAME_COUNT];

   // The finished token commits once the response register can take its result.
   assign commit = tok_last.valid && (!rsp_valid_ff || rsp_tready);
   assign hold   = tok_last.valid && !commit;

   // Replacement decision: hit frame, else first empty frame, else LRU frame.
   always_comb begin
      frame_sel = tok_last.lru_idx;
      evicted   = 1'b0;
      ev_page   = '0;
      upd       = '0;
      upd.valid = commit;
      upd.page  = PAGE_W_MAX'(page_ff);
      if (tok_last.hit) begin
         frame_sel = tok_last.hit_idx;
         upd.limit = tok_last.hit_rank;
      end else if (tok_last.empty) begin
         frame_sel   = tok_last.empty_idx;
         upd.write   = 1'b1;
         upd.age_all = 1'b1;
      end else begin
         evicted   = 1'b1;
         ev_page   = tok_last.lru_page;
         upd.write = 1'b1;
         upd.limit = tok_last.lru_rank;
      end
      upd.idx = frame_sel;
   end

   assign req_page_ext = PAGE_W_MAX'(req_tdata);

   always_comb begin
      cfg_in       = cfg_ff;
      busy_in      = busy_ff;
      start_in     = req_accept;
      page_in      = page_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_valid && csr_ready) begin
         cfg_in = csr_data;
      end
      if (req_accept) begin
         busy_in = 1'b1;
         page_in = req_page_ext[PAGE_BITS-1:0];
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (tok_last.hit) begin
            if (hit_cnt_ff != '1) begin
               hit_cnt_in = hit_cnt_ff + COUNT_W'(1);
            end
         end else if (fault_cnt_ff != '1) begin
            fault_cnt_in = fault_cnt_ff + COUNT_W'(1);
         end
         rsp_data_in = '0;
         rsp_data_in[RSP_HIT_BIT]                   = tok_last.hit;
         rsp_data_in[RSP_IDX_LO +: FRAME_IDX_W]     = frame_sel[FRAME_IDX_W-1:0];
         rsp_data_in[RSP_EVV_BIT]                   = evicted;
         rsp_data_in[RSP_EVP_LO +: PAGE_W]          = ev_page[PAGE_W-1:0];
         rsp_data_in[RSP_HTOT_LO +: COUNT_W]        = hit_cnt_in;
         rsp_data_in[RSP_FTOT_LO +: COUNT_W]        = fault_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/lrupr_checker.sv */
// Port-level checks for lru_page_replacement and the bind that attaches them.
// Depends on lrupr_pkg and lru_page_replacement.
module lrupr_assert
   import lrupr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // One request is in flight at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A hit never evicts a page.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_HIT_BIT] |-> !rsp_tdata[RSP_EVV_BIT])
      else $error("hit reported an eviction");

   // Without an eviction the evicted page reads as zero.
   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_EVV_BIT] |-> rsp_tdata[RSP_EVP_LO +: PAGE_W] == '0)
      else $error("evicted page nonzero without an eviction");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind lru_page_replacement lrupr_assert u_lrupr_assert (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/lrupr_checker.sv */
// Response checker for the LRU page replacement block: tracks frame contents, recency
// and counters, predicts each lookup and compares every response. Depends on lrupr_pkg.
module lrupr_checker
   import lrupr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [PAGE_W-1:0]      req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_data,
   output int                     outstanding,
   output int                     mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAMES = FRAME_COUNT_DEF;

   typedef struct {
      logic                   hit;
      logic [FRAME_IDX_W-1:0] frame;
      logic                   ev_valid;
      logic [PAGE_W-1:0]      ev_page;
      logic [COUNT_W-1:0]     hits;
      logic [COUNT_W-1:0]     faults;
   } lookup_type;

   logic [PAGE_W-1:0]      page_of  [FRAMES];
   logic                   resident [FRAMES];
   logic [FRAME_IDX_W-1:0] age      [FRAMES];
   logic [COUNT_W-1:0]     hit_cnt;
   logic [COUNT_W-1:0]     fault_cnt;
   logic [CFG_W-1:0]       frames_cfg;
   lookup_type             lookup_q [$];
   lookup_type             want;
   lookup_type             seen;

   // Frame f becomes the youngest; resident frames younger than limit grow one older.
   function automatic void refresh_age(int f, int limit);
      for (int i = 0; i < FRAMES; i++) begin
         if (i != f && resident[i] && int'(age[i]) < limit) age[i]++;
      end
      age[f] = '0;
   endfunction

   function automatic lookup_type predict_lookup(logic [PAGE_W-1:0] page);
      lookup_type r;
      int         act;
      int         f;
      logic       found;
      act   = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
      r     = '{default: '0};
      f     = 0;
      found = 1'b0;
      for (int i = 0; i < act; i++) begin
         if (!found && resident[i] && page_of[i] == page) begin
            found = 1'b1;
            f     = i;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         refresh_age(f, int'(age[f]));
         if (hit_cnt != '1) hit_cnt++;
      end else begin
         for (int i = 0; i < act; i++) begin
            if (!found && !resident[i]) begin
               found = 1'b1;
               f     = i;
            end
         end
         if (found) begin
            resident[f] = 1'b1;
            page_of[f]  = page;
            refresh_age(f, FRAMES);
         end else begin
            // Every active frame is full: the oldest active frame gives way.
            f = 0;
            for (int i = 1; i < act; i++) begin
               if (age[i] > age[f]) f = i;
            end
            r.ev_valid = 1'b1;
            r.ev_page  = page_of[f];
            page_of[f] = page;
            refresh_age(f, int'(age[f]));
         end
         if (fault_cnt != '1) fault_cnt++;
      end
      r.frame  = FRAME_IDX_W'(f);
      r.hits   = hit_cnt;
      r.faults = fault_cnt;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            page_of[i]  = '0;
            resident[i] = 1'b0;
            age[i]      = '0;
         end
         hit_cnt     = '0;
         fault_cnt   = '0;
         frames_cfg  = CFG_RESET;
         lookup_q.delete();
         outstanding = 0;
         mismatches  = 0;
      end else begin
         if (csr_valid && csr_ready) frames_cfg = csr_data;
         if (req_tvalid && req_tready) lookup_q.push_back(predict_lookup(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            seen.hit      = rsp_tdata[RSP_HIT_BIT];
            seen.frame    = rsp_tdata[RSP_IDX_LO +: FRAME_IDX_W];
            seen.ev_valid = rsp_tdata[RSP_EVV_BIT];
            seen.ev_page  = rsp_tdata[RSP_EVP_LO +: PAGE_W];
            seen.hits     = rsp_tdata[RSP_HTOT_LO +: COUNT_W];
            seen.faults   = rsp_tdata[RSP_FTOT_LO +: COUNT_W];
            if (lookup_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request pending: hit %0b frame %0d", $realtime,
                           seen.hit, seen.frame);
            end else begin
               want = lookup_q.pop_front();
               if (want.hit !== seen.hit || want.frame !== seen.frame ||
                   want.ev_valid !== seen.ev_valid || want.ev_page !== seen.ev_page ||
                   want.hits !== seen.hits || want.faults !== seen.faults) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: mismatch, expected hit %0b frame %0d evict %0b/%h ",
                               "totals %0d/%0d, got hit %0b frame %0d evict %0b/%h totals %0d/%0d"},
                              $realtime, want.hit, want.frame, want.ev_valid, want.ev_page,
                              want.hits, want.faults, seen.hit, seen.frame, seen.ev_valid,
                              seen.ev_page, seen.hits, seen.faults);
               end
            end
         end
         outstanding = lookup_q.size();
      end
   end

endmodule

/* test/tb.sv */
// Top of the LRU page replacement testbench: clock, reset, request and configuration
// stimulus, response back-pressure, watchdog and verdict. Depends on lrupr_pkg,
// lru_page_replacement and lrupr_checker.
module tb
   import lrupr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // A lookup walks the whole frame chain before its response appears; the settle time
   // at the end covers that with some margin.
   localparam int SETTLE_CYCLES = FRAME_COUNT_DEF + 8;
   // Cycles without any handshake before the run is declared hung. The slowest honest
   // stretch is the long receiver hold-off plus one lookup, far below this.
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 120;
   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ITEMS = 200;
   localparam int POOL_SIZE     = 20;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PAGE_W-1:0]      req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_data   = '0;

   int outstanding;
   int mismatches;

   // Idle percentages for each side, changed only between phases while the block is idle.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   int stall_cycles = 0;
   int rx_req_seen  = 0;
   int rx_hold_left = 0;

   // Register value last written; the stimulus uses it to size its page pool.
   logic [CFG_W-1:0]  frames_now = CFG_RESET;
   logic [PAGE_W-1:0] page_pool [POOL_SIZE];

   lru_page_replacement u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lrupr_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side. Normally it drops rsp_tready at random; when the 300th and the
   // 1100th requests go in, it holds off for a long stretch so that the response
   // register stays full and the block has to push back on the request side while
   // the sender keeps offering.
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         rx_req_seen++;
         if (rx_req_seen % 800 == 300) rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left != 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Watchdog: any handshake restarts the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("** lru_page_replacement: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offers one page request and returns at the edge where it is taken. Idle cycles
   // go in front of the request, so tvalid is only ever assigned once per edge and
   // stays high between back-to-back requests.
   task automatic send_page(input logic [PAGE_W-1:0] page);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      do @(posedge clock); while (!req_tready);
   endtask

   // Writes the frame count; called at a rising edge while the block is idle.
   task automatic set_frames(input logic [CFG_W-1:0] value);
      csr_valid  <= 1'b1;
      csr_data   <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      frames_now = value;
   endtask

   // Stops offering and waits for every predicted response. It returns on a falling
   // edge, where the checker's count has settled, so the caller steps to the next
   // rising edge before driving anything again.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // Most requests reuse a small pool slightly larger than the active frame set, so
   // the stream has real locality and mixes hits, fills and evictions; the rest are
   // arbitrary 16-bit pages that mostly fault.
   function automatic logic [PAGE_W-1:0] pick_page(int pool_n);
      if ($urandom_range(0, 99) < 80) return page_pool[$urandom_range(0, pool_n - 1)];
      return PAGE_W'($urandom);
   endfunction

   initial begin : stimulus
      logic [CFG_W-1:0] seg_cfg [SEGMENTS];
      int               act;
      int               pool_n;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, all 16 frames active from reset. Page zero must fault into an
      // empty frame and then hit; the all-ones page behaves the same way.
      send_page(16'h0000);
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'hFFFF);
      // Fill the remaining frames in order, lowest free frame first.
      for (int p = 1; p <= 14; p++) send_page(PAGE_W'(p));
      // All frames full: the next faults evict the oldest, page zero first, then the
      // all-ones page.
      send_page(16'h8000);
      send_page(16'h0000);

      // A register value of zero acts as one frame. The upper frames keep their pages
      // but are neither searched nor replaced, and their ages keep moving.
      drain();
      @(posedge clock);
      set_frames(CFG_W'(0));
      send_page(16'h0007);
      send_page(16'h0007);
      send_page(16'h0009);

      // A value above the frame count acts as the full set again, so the hidden pages
      // become reachable: page 3 hits in its old frame.
      drain();
      @(posedge clock);
      set_frames(CFG_W'(31));
      send_page(16'h0003);
      send_page(16'h0007);

      // Random part in six segments. Idle pattern: sender light and receiver heavy for
      // the first two, the reverse for the next two, none for the last two. The frame
      // count covers one, the full set, a small set, both out-of-range encodings and
      // one random value.
      seg_cfg[0] = CFG_W'(1);
      seg_cfg[1] = CFG_W'(16);
      seg_cfg[2] = CFG_W'(5);
      seg_cfg[3] = CFG_W'(31);
      seg_cfg[4] = CFG_W'(0);
      seg_cfg[5] = CFG_W'($urandom_range(0, 31));
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         case (seg / 2)
            0: begin
               tx_idle_pct = 25;
               rx_idle_pct = 78;
            end
            1: begin
               tx_idle_pct = 78;
               rx_idle_pct = 25;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         @(posedge clock);
         set_frames(seg_cfg[seg]);
         act = (frames_now == 0) ? 1 :
               (frames_now > FRAME_COUNT_DEF) ? FRAME_COUNT_DEF : int'(frames_now);
         pool_n = act + 1 + $urandom_range(0, 3);
         if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
         for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);
         for (int n = 0; n < SEGMENT_ITEMS; n++) send_page(pick_page(pool_n));
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("** lru_page_replacement: PASSED **");
      end else begin
         $display("** lru_page_replacement: FAILED **");
      end
      $finish;
   end

endmodule
